FILE: sv/bttab_pkg.sv
`default_nettype none
package bttab_pkg;

  localparam int NUM_SLOTS = 16;

  localparam int ID_W      = 16;
  localparam int TEMP_W    = 7;
  localparam int SLOT_W    = 5;
  localparam int BCNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int OUT_T_W   = 8;

  // Count of active slots, 0..NUM_SLOTS.
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  // Width that holds both a slot number and the board_count register.
  localparam int CMP_W = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
  // Sum of up to NUM_SLOTS temperatures.
  localparam int SUM_W = TEMP_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OUT_T_W-1:0] NOT_FOUND_TEMP = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WARN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WARN   = 2'd2;

  typedef enum logic [1:0] {
    ACT_RECORD  = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_AVERAGE = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Token that walks the cell chain for a lookup or an average.
  typedef struct packed {
    logic              valid;
    logic              is_avg;
    logic [ID_W-1:0]   want;
    logic [CNT_W-1:0]  rem;
    logic              found;
    logic [TEMP_W-1:0] temp;
    logic [SUM_W-1:0]  sum;
  } tok_t;

endpackage
`default_nettype wire

FILE: sv/board_temperature_table_top.sv
`default_nettype none
// Board temperature table. Each transaction on the input stream gives exactly one
// result transaction. A record writes the id and temperature of a slot held in a
// chain of NUM_SLOTS cells and passes from S_IDLE through S_DONE to the output
// register. A lookup or an average sends a token down the cell chain, one cell per
// cycle; a lookup then goes through S_DONE to the output register, and an average
// first runs a bit-serial divider in S_DIV. A stalled output holds the result in
// S_DONE until the output register is free. One item is in work at a time; the next
// one is taken as soon as the result has moved to the output register. The table is
// all zero after reset; configuration writes are always accepted and must happen
// only while the block is idle.
module board_temperature_table_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [4:0] slot, [36:5] sensor_word, [52:37] board_id, [55:53] zero
  input  logic [bttab_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] action
  input  logic [bttab_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] temperature, [8] found, [9] warning, [15:10] zero
  output logic [bttab_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bttab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bttab_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import bttab_pkg::*;

  state_t             state_r, state_nxt;
  logic [BCNT_W-1:0]  board_count_r;
  logic [TEMP_W-1:0]  low_warn_r;
  logic [TEMP_W-1:0]  high_warn_r;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   n_cur;
  logic [OUT_T_W-1:0] res_temp_r, res_temp_nxt;
  logic               res_found_r, res_found_nxt;
  logic               res_warn_r, res_warn_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_T_W-1:0] out_temp_r, out_temp_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_warn_r, out_warn_nxt;

  logic               in_acc;
  action_t            act;
  logic [SLOT_W-1:0]  in_slot;
  logic [31:0]        in_word;
  logic [ID_W-1:0]    in_board_id;
  logic [TEMP_W-1:0]  rec_temp;
  logic               rec_warn;
  logic [NUM_SLOTS-1:0] wr_en;
  tok_t               chain [NUM_SLOTS+1];
  tok_t               tok_last;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quot;

  assign in_slot     = in_tdata[4:0];
  assign in_word     = in_tdata[36:5];
  assign in_board_id = in_tdata[52:37];
  assign act         = action_t'(in_tuser);
  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;

  assign rec_temp = in_word[TEMP_W-1:0];
  assign rec_warn = (rec_temp < low_warn_r) || (rec_temp > high_warn_r);

  // A board_count above the table size covers the whole table.
  assign n_cur = (CMP_W'(board_count_r) > CMP_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                              : CNT_W'(board_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_count_r <= BCNT_W'(1);
      low_warn_r    <= '0;
      high_warn_r   <= TEMP_W'(127);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOARD_COUNT: board_count_r <= cfg_data[BCNT_W-1:0];
        CFG_LOW_WARN:    low_warn_r    <= cfg_data[TEMP_W-1:0];
        CFG_HIGH_WARN:   high_warn_r   <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = in_acc && ((act == ACT_LOOKUP) || (act == ACT_AVERAGE));
    chain[0].is_avg = (act == ACT_AVERAGE);
    chain[0].want   = in_board_id;
    chain[0].rem    = n_cur;
  end

  // Slot numbers run from one; slot zero and slots past the table write nothing.
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    assign wr_en[k] = in_acc && (act == ACT_RECORD) && (CMP_W'(in_slot) == CMP_W'(k + 1));

    bttab_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en[k]),
      .wr_id   (in_word[31:16]),
      .wr_temp (rec_temp),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  assign tok_last  = chain[NUM_SLOTS];
  assign div_start = (state_r == S_SCAN) && tok_last.valid && tok_last.is_avg;

  bttab_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tok_last.sum),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    res_temp_nxt  = res_temp_r;
    res_found_nxt = res_found_r;
    res_warn_nxt  = res_warn_r;
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    out_found_nxt = out_found_r;
    out_warn_nxt  = out_warn_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          n_nxt         = n_cur;
          res_temp_nxt  = '0;
          res_found_nxt = 1'b0;
          res_warn_nxt  = 1'b0;
          unique case (act)
            ACT_RECORD: begin
              res_warn_nxt = rec_warn;
              state_nxt    = S_DONE;
            end
            ACT_LOOKUP, ACT_AVERAGE: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_last.valid) begin
          if (tok_last.is_avg) begin
            state_nxt = S_DIV;
          end else begin
            res_temp_nxt  = tok_last.found ? {1'b0, tok_last.temp} : NOT_FOUND_TEMP;
            res_found_nxt = tok_last.found;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_temp_nxt  = (n_r == '0) ? '0 : {1'b0, div_quot[TEMP_W-1:0]};
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = res_temp_r;
          out_found_nxt = res_found_r;
          out_warn_nxt  = res_warn_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    res_temp_r  <= res_temp_nxt;
    res_found_r <= res_found_nxt;
    res_warn_r  <= res_warn_nxt;
    out_temp_r  <= out_temp_nxt;
    out_found_r <= out_found_nxt;
    out_warn_r  <= out_warn_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_warn_r, out_found_r, out_temp_r};

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> (state_r == S_SCAN))
    else $error("token left the cell chain outside a scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_found_no_warn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_warn_r))
    else $error("result carries both found and warning");

  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r && !out_warn_r && (out_temp_r != '0))
      |-> (out_temp_r == NOT_FOUND_TEMP))
    else $error("failed lookup with wrong temperature code");

endmodule
`default_nettype wire

FILE: sv/bttab_cell.sv
`default_nettype none
module bttab_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [bttab_pkg::ID_W-1:0]   wr_id,
  input  logic [bttab_pkg::TEMP_W-1:0] wr_temp,
  input  bttab_pkg::tok_t              tok_in,
  output bttab_pkg::tok_t              tok_out
);
  import bttab_pkg::*;

  logic [ID_W-1:0]   id_r;
  logic [TEMP_W-1:0] temp_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '0;
      temp_r <= '0;
    end else if (wr_en) begin
      id_r   <= wr_id;
      temp_r <= wr_temp;
    end
  end

  // The remaining count tells the cell whether its slot lies within board_count.
  always_comb begin
    tok_nxt = tok_in;
    active  = (tok_in.rem != '0);
    if (active) begin
      tok_nxt.rem = tok_in.rem - 1'b1;
    end
    if (active && !tok_in.is_avg && !tok_in.found && (id_r == tok_in.want)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.temp  = temp_r;
    end
    if (active && tok_in.is_avg) begin
      tok_nxt.sum = tok_in.sum + SUM_W'(temp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

FILE: sv/bttab_div.sv
`default_nettype none
module bttab_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bttab_pkg::SUM_W-1:0] dividend,
  input  logic [bttab_pkg::CNT_W-1:0] divisor,
  output logic                        done,
  output logic [bttab_pkg::SUM_W-1:0] quot
);
  import bttab_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(SUM_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

endmodule
`default_nettype wire
